// File: rtl/cse_pkg.sv
// Package for the cosine similarity engine: widths, sequencer states and control structs.
package cse_pkg;

  // Accumulator width and derived widths of the ratio datapath
  localparam int ACC_W      = 44;
  localparam int MUL_W      = 2 * ACC_W;
  localparam int ADD_W      = MUL_W + 2;
  localparam int FRAC_W     = 14;
  localparam int QUO_W      = 2 * FRAC_W;
  localparam int Q_W        = FRAC_W + 1;
  localparam int CNT_W      = 6;
  localparam int SIM_W      = 16;
  localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(1 << FRAC_W);

  // Top-level sequencer
  typedef enum logic [1:0] {
    T_IDLE,
    T_MAC,
    T_RATIO,
    T_EMIT
  } top_st_t;

  // Ratio unit sequencer
  typedef enum logic [2:0] {
    R_IDLE,
    R_MULP,
    R_MULR,
    R_CMP,
    R_DIV,
    R_SQRT,
    R_DONE
  } rat_st_t;

  // Control into the accumulator unit
  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctrl_t;

endpackage

// File: rtl/cse_acc.sv
// Accumulator unit: one shared multiplier feeds three saturating accumulators, one per cycle.
module cse_acc #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cse_pkg::acc_ctrl_t                     ctrl,
  input  logic signed [ELEM_WIDTH-1:0]           elem_a,
  input  logic signed [ELEM_WIDTH-1:0]           elem_b,
  output logic                                   done,
  output logic signed [cse_pkg::ACC_W-1:0]       dot_sum,
  output logic signed [cse_pkg::ACC_W-1:0]       sq_a,
  output logic signed [cse_pkg::ACC_W-1:0]       sq_b
);

  localparam int ACC_W  = cse_pkg::ACC_W;
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int WIDE   = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
  localparam logic signed [WIDE-1:0] MAXV =
    {{(WIDE-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [WIDE-1:0] MINV = ~MAXV;

  logic signed [ELEM_WIDTH-1:0] a_r, b_r;
  logic                         busy_r, done_r;
  logic [1:0]                   phase_r;
  logic signed [ACC_W-1:0]      dot_r, sqa_r, sqb_r;

  logic signed [ELEM_WIDTH-1:0] op_x, op_y;
  logic signed [PROD_W-1:0]     prod;
  logic signed [WIDE-1:0]       prod_w, prod_s, acc_w, sum_w, sum_s;
  logic signed [ACC_W-1:0]      acc_sel, acc_nxt;

  // Operand selection per phase: a*b, a*a, b*b
  always_comb begin
    unique case (phase_r)
      2'd0:    begin op_x = a_r; op_y = b_r; acc_sel = dot_r; end
      2'd1:    begin op_x = a_r; op_y = a_r; acc_sel = sqa_r; end
      default: begin op_x = b_r; op_y = b_r; acc_sel = sqb_r; end
    endcase
  end

  // Shared multiplier and saturating add
  always_comb begin
    prod   = op_x * op_y;
    prod_w = WIDE'(prod);
    if (prod_w > MAXV)      prod_s = MAXV;
    else if (prod_w < MINV) prod_s = MINV;
    else                    prod_s = prod_w;
    acc_w = WIDE'(acc_sel);
    sum_w = acc_w + prod_s;
    if (sum_w > MAXV)      sum_s = MAXV;
    else if (sum_w < MINV) sum_s = MINV;
    else                   sum_s = sum_w;
    acc_nxt = sum_s[ACC_W-1:0];
  end

  // Sequencer and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 2'd0;
      dot_r   <= '0;
      sqa_r   <= '0;
      sqb_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        a_r     <= elem_a;
        b_r     <= elem_b;
        busy_r  <= 1'b1;
        phase_r <= 2'd0;
      end else if (busy_r) begin
        unique case (phase_r)
          2'd0:    dot_r <= acc_nxt;
          2'd1:    sqa_r <= acc_nxt;
          default: sqb_r <= acc_nxt;
        endcase
        if (phase_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        phase_r <= phase_r + 2'd1;
      end
    end
  end

  assign done    = done_r;
  assign dot_sum = dot_r;
  assign sq_a    = sqa_r;
  assign sq_b    = sqb_r;

  // Sums of squares never go negative
  a_sq_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !sqa_r[ACC_W-1] && !sqb_r[ACC_W-1]) else $error("negative sum of squares");

  // Clear empties all accumulators
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> (dot_r == '0 && sqa_r == '0 && sqb_r == '0))
    else $error("accumulators not cleared");

  // Done pulses only at the end of a pass
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r) else $error("stray done");

endmodule

// File: rtl/cse_ratio.sv
// Ratio unit: shift-add multiply, restoring divide and digit square root on one shared adder.
module cse_ratio (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cse_pkg::ACC_W-1:0]    d_mag,
  input  logic [cse_pkg::ACC_W-1:0]    norm_a,
  input  logic [cse_pkg::ACC_W-1:0]    norm_b,
  output logic                         done,
  output logic [cse_pkg::Q_W-1:0]      q
);

  localparam int ACC_W = cse_pkg::ACC_W;
  localparam int MUL_W = cse_pkg::MUL_W;
  localparam int ADD_W = cse_pkg::ADD_W;
  localparam int QUO_W = cse_pkg::QUO_W;
  localparam int Q_W   = cse_pkg::Q_W;
  localparam int CNT_W = cse_pkg::CNT_W;

  cse_pkg::rat_st_t st_r, st_nxt;

  logic [ACC_W-1:0] d_r, nb_r, mplier_r, mplier_nxt;
  logic [MUL_W-1:0] mcand_r, mcand_nxt, p_r, p_nxt;
  logic [ADD_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;

  // Shared add/subtract unit; carry out of a subtract means opa >= opb
  logic [ADD_W-1:0] opa, opb, sum;
  logic             sub, ge;
  logic [ADD_W:0]   full;

  always_comb begin
    full = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {{ADD_W{1'b0}}, sub};
    sum  = full[ADD_W-1:0];
    ge   = full[ADD_W];
  end

  // Sequencer
  always_comb begin
    st_nxt     = st_r;
    mplier_nxt = mplier_r;
    mcand_nxt  = mcand_r;
    p_nxt      = p_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    root_nxt   = root_r;
    bit_nxt    = bit_r;
    cnt_nxt    = cnt_r;
    q_nxt      = q_r;
    opa        = '0;
    opb        = '0;
    sub        = 1'b0;
    unique case (st_r)
      cse_pkg::R_IDLE: begin
        if (start) begin
          mcand_nxt  = MUL_W'(norm_a);
          mplier_nxt = norm_b;
          p_nxt      = '0;
          cnt_nxt    = '0;
          st_nxt     = cse_pkg::R_MULP;
        end
      end
      cse_pkg::R_MULP, cse_pkg::R_MULR: begin
        opa = (st_r == cse_pkg::R_MULP) ? ADD_W'(p_r) : rem_r;
        opb = mplier_r[0] ? ADD_W'(mcand_r) : '0;
        if (st_r == cse_pkg::R_MULP) p_nxt = sum[MUL_W-1:0];
        else                         rem_nxt = sum;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ACC_W - 1)) begin
          cnt_nxt = '0;
          if (st_r == cse_pkg::R_MULP) begin
            mcand_nxt  = MUL_W'(d_r);
            mplier_nxt = d_r;
            rem_nxt    = '0;
            st_nxt     = cse_pkg::R_MULR;
          end else begin
            st_nxt = cse_pkg::R_CMP;
          end
        end
      end
      cse_pkg::R_CMP: begin
        // dot^2 >= normA*normB clamps the ratio to one
        opa = rem_r;
        opb = ADD_W'(p_r);
        sub = 1'b1;
        quo_nxt = '0;
        if (ge) begin
          q_nxt  = cse_pkg::ONE_Q14;
          st_nxt = cse_pkg::R_DONE;
        end else begin
          st_nxt = cse_pkg::R_DIV;
        end
      end
      cse_pkg::R_DIV: begin
        // quotient floor(dot^2 * 2^28 / (normA*normB)), one bit per cycle
        opa = rem_r << 1;
        opb = ADD_W'(p_r);
        sub = 1'b1;
        rem_nxt = ge ? sum : (rem_r << 1);
        quo_nxt = {quo_r[QUO_W-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          cnt_nxt  = '0;
          root_nxt = '0;
          bit_nxt  = QUO_W'(1) << (QUO_W - 2);
          st_nxt   = cse_pkg::R_SQRT;
        end
      end
      cse_pkg::R_SQRT: begin
        // integer square root, one result bit per cycle
        opa = ADD_W'(quo_r);
        opb = ADD_W'(root_r | bit_r);
        sub = 1'b1;
        if (ge) begin
          quo_nxt  = sum[QUO_W-1:0];
          root_nxt = (root_r >> 1) | bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          q_nxt  = root_nxt[Q_W-1:0];
          st_nxt = cse_pkg::R_DONE;
        end
      end
      default: begin
        st_nxt = cse_pkg::R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= cse_pkg::R_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (st_r == cse_pkg::R_IDLE && start) begin
      d_r  <= d_mag;
      nb_r <= norm_b;
    end
    mplier_r <= mplier_nxt;
    mcand_r  <= mcand_nxt;
    p_r      <= p_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    root_r   <= root_nxt;
    bit_r    <= bit_nxt;
    cnt_r    <= cnt_nxt;
    q_r      <= q_nxt;
  end

  assign done = (st_r == cse_pkg::R_DONE);
  assign q    = q_r;

  // Result never exceeds one
  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> q_r <= cse_pkg::ONE_Q14) else $error("ratio out of range");

  // Divide only runs while dot^2 is below the norm product
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == cse_pkg::R_DIV |-> rem_r < ADD_W'(p_r)) else $error("divide remainder too big");

  // Start is only honored from idle
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == cse_pkg::R_IDLE && start) |=> st_r == cse_pkg::R_MULP && nb_r == $past(norm_b))
    else $error("ratio start lost");

endmodule

// File: rtl/cosine_similarity_engine.sv
// Cosine similarity engine top level: item sequencer, accumulator and ratio units, result register.
//
//  channel  direction  ports                                   handshake
//  in       input      in_elem_a, in_elem_b, in_last           in_valid / in_ready
//  out      output     out_similarity, out_zero_norm           out_valid / out_ready
//
// Between one accept and the next, each pair makes three passes through the shared
// multiplier, then a handoff to the sequencer and a return to idle.
// A last pair with nonzero norms runs 44 + 44 shift-add multiply steps, one compare, 28 divide
// steps and 14 square-root steps on the shared adder; divide and square root are skipped when
// the ratio clamps at one, and the ratio unit is skipped when a norm is zero.
// Reset (rst_n low, synchronous) clears the sequencers and the accumulators.
// A waiting result sits in the output register; the next pair may be accepted meanwhile,
// and the next result waits in T_EMIT, with in_ready low, until that register is taken.
module cosine_similarity_engine #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ELEM_WIDTH-1:0]        in_elem_a,
  input  logic signed [ELEM_WIDTH-1:0]        in_elem_b,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cse_pkg::SIM_W-1:0]    out_similarity,
  output logic                                out_zero_norm
);

  localparam int ACC_W = cse_pkg::ACC_W;
  localparam int Q_W   = cse_pkg::Q_W;
  localparam int SIM_W = cse_pkg::SIM_W;
  localparam logic signed [SIM_W-1:0] ONE_S = SIM_W'(cse_pkg::ONE_Q14);

  cse_pkg::top_st_t  st_r, st_nxt;
  cse_pkg::acc_ctrl_t acc_ctrl;

  logic                    last_r, last_nxt;
  logic                    acc_done, rat_start, rat_done;
  logic signed [ACC_W-1:0] dot_sum, sq_a, sq_b;
  logic [ACC_W-1:0]        d_mag;
  logic [Q_W-1:0]          rat_q;
  logic [Q_W-1:0]          q_r, q_nxt;
  logic                    zero_r, zero_nxt, neg_r, neg_nxt;
  logic                    ov_r, ov_nxt;
  logic signed [SIM_W-1:0] sim_r, sim_nxt;
  logic                    zn_r, zn_nxt;
  logic                    accept, norm_zero, emit;

  assign accept    = in_valid && in_ready;
  assign norm_zero = (sq_a == '0) || (sq_b == '0);
  assign d_mag     = dot_sum[ACC_W-1] ? (ACC_W'(0) - dot_sum) : dot_sum;
  assign emit      = (st_r == cse_pkg::T_EMIT) && (!ov_r || out_ready);

  cse_acc #(.ELEM_WIDTH(ELEM_WIDTH)) u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (acc_ctrl),
    .elem_a  (in_elem_a),
    .elem_b  (in_elem_b),
    .done    (acc_done),
    .dot_sum (dot_sum),
    .sq_a    (sq_a),
    .sq_b    (sq_b)
  );

  cse_ratio u_ratio (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (rat_start),
    .d_mag  (d_mag),
    .norm_a (sq_a),
    .norm_b (sq_b),
    .done   (rat_done),
    .q      (rat_q)
  );

  // Item sequencer
  always_comb begin
    st_nxt         = st_r;
    last_nxt       = last_r;
    q_nxt          = q_r;
    zero_nxt       = zero_r;
    neg_nxt        = neg_r;
    rat_start      = 1'b0;
    acc_ctrl.start = 1'b0;
    acc_ctrl.clear = 1'b0;
    in_ready       = (st_r == cse_pkg::T_IDLE);
    unique case (st_r)
      cse_pkg::T_IDLE: begin
        if (accept) begin
          acc_ctrl.start = 1'b1;
          last_nxt       = in_last;
          st_nxt         = cse_pkg::T_MAC;
        end
      end
      cse_pkg::T_MAC: begin
        if (acc_done) begin
          neg_nxt  = dot_sum[ACC_W-1];
          zero_nxt = norm_zero;
          q_nxt    = '0;
          if (!last_r) begin
            st_nxt = cse_pkg::T_IDLE;
          end else if (norm_zero) begin
            st_nxt = cse_pkg::T_EMIT;
          end else begin
            rat_start = 1'b1;
            st_nxt    = cse_pkg::T_RATIO;
          end
        end
      end
      cse_pkg::T_RATIO: begin
        if (rat_done) begin
          q_nxt  = rat_q;
          st_nxt = cse_pkg::T_EMIT;
        end
      end
      default: begin
        if (emit) begin
          acc_ctrl.clear = 1'b1;
          st_nxt         = cse_pkg::T_IDLE;
        end
      end
    endcase
  end

  // Output register
  always_comb begin
    ov_nxt  = ov_r && !out_ready;
    sim_nxt = sim_r;
    zn_nxt  = zn_r;
    if (emit) begin
      ov_nxt  = 1'b1;
      sim_nxt = neg_r ? (SIM_W'(0) - SIM_W'(q_r)) : SIM_W'(q_r);
      zn_nxt  = zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= cse_pkg::T_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    q_r    <= q_nxt;
    zero_r <= zero_nxt;
    neg_r  <= neg_nxt;
    sim_r  <= sim_nxt;
    zn_r   <= zn_nxt;
  end

  assign out_valid      = ov_r;
  assign out_similarity = sim_r;
  assign out_zero_norm  = zn_r;

  // A zero norm result carries a zero similarity
  a_zero_sim: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && zn_r) |-> sim_r == '0) else $error("zero norm with nonzero similarity");

  // Similarity stays within plus or minus one
  a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (sim_r <= ONE_S) && (sim_r >= -ONE_S))
    else $error("similarity out of range");

  // A result is loaded only when the output slot is free or being taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r && $stable(sim_r) && $stable(zn_r))
    else $error("pending result overwritten");

endmodule

// File: sim/tb.sv
// Self-checking testbench for cosine_similarity_engine with directed and random vector streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ELEM_W   = 16;
  localparam int IDLE_PCT = 27;
  localparam int CYC_MAX  = 2_000_000;
  localparam int SAT_LEN  = 400;
  localparam int RND_CNT  = 1480;

  typedef struct packed {
    logic signed [cse_pkg::SIM_W-1:0] sim;
    logic                             zero;
  } sim_res_t;

  // One row of the directed table; fixed marks a hand-typed expectation
  typedef struct {
    logic signed [ELEM_W-1:0]         a;
    logic signed [ELEM_W-1:0]         b;
    logic                             last;
    logic                             fixed;
    logic signed [cse_pkg::SIM_W-1:0] sim;
    logic                             zero;
  } vec_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic signed [ELEM_W-1:0]         in_elem_a = '0;
  logic signed [ELEM_W-1:0]         in_elem_b = '0;
  logic                             in_last = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [cse_pkg::SIM_W-1:0] out_similarity;
  logic                             out_zero_norm;

  sim_res_t  sim_q[$];
  longint    dot_acc, sqa_acc, sqb_acc;
  int        errors = 0;
  int        cycles = 0;
  bit        calm = 1'b0;
  bit        done_flag = 1'b0;
  vec_row_t  dir_tab[$];

  cosine_similarity_engine #(.ELEM_WIDTH(ELEM_W)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic longint sat44(input longint v);
    longint hi = (longint'(1) <<< 43) - 1;
    longint lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Largest q in [0,16384] with q*q*na*nb <= d*d*2^28
  function automatic logic [15:0] cos_q14(input logic [63:0] d, input logic [63:0] na,
                                          input logic [63:0] nb);
    logic [127:0] prod, rhs, lhs;
    int unsigned  lo, hi, mid;
    prod = 128'(na) * 128'(nb);
    rhs  = (128'(d) * 128'(d)) << 28;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = prod * 128'(mid * mid);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 16'(lo);
  endfunction

  // Accumulate one pair; returns 1 with the similarity when the pair closes a vector
  function automatic bit sim_update(input logic signed [ELEM_W-1:0] a,
                                    input logic signed [ELEM_W-1:0] b,
                                    input logic last, output sim_res_t r);
    longint      av = a;
    longint      bv = b;
    logic [15:0] q;
    r = '0;
    dot_acc = sat44(dot_acc + sat44(av * bv));
    sqa_acc = sat44(sqa_acc + sat44(av * av));
    sqb_acc = sat44(sqb_acc + sat44(bv * bv));
    if (!last) return 1'b0;
    if (sqa_acc <= 0 || sqb_acc <= 0) begin
      r.zero = 1'b1;
    end else begin
      q = cos_q14(64'(dot_acc < 0 ? -dot_acc : dot_acc), 64'(sqa_acc), 64'(sqb_acc));
      r.sim = dot_acc < 0 ? -$signed(q) : $signed(q);
    end
    dot_acc = 0;
    sqa_acc = 0;
    sqb_acc = 0;
    return 1'b1;
  endfunction

  // Present one item and hold it until accepted, with random idle cycles first
  task automatic send(input logic signed [ELEM_W-1:0] a, input logic signed [ELEM_W-1:0] b,
                      input logic last, input bit fixed = 0,
                      input sim_res_t fixed_res = '0);
    sim_res_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_elem_a <= a;
    in_elem_b <= b;
    in_last   <= last;
    do @(posedge clk); while (!in_ready);
    if (sim_update(a, b, last, r)) sim_q = {sim_q, (fixed ? fixed_res : r)};
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vec_row_t row(input int a, input int b, input bit last,
                                   input bit fixed = 0, input int sim = 0,
                                   input bit zero = 0);
    vec_row_t t;
    t.a = 16'(a);
    t.b = 16'(b);
    t.last = last;
    t.fixed = fixed;
    t.sim = 16'(sim);
    t.zero = zero;
    return t;
  endfunction

  function automatic void add_row(input vec_row_t t);
    dir_tab = {dir_tab, t};
  endfunction

  // Result side: check each item, then draw the next ready
  always @(posedge clk) begin
    sim_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (sim_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = sim_q.pop_front();
        if (out_similarity !== e.sim)
          report($sformatf("similarity %0d, expected %0d", out_similarity, e.sim));
        if (out_zero_norm !== e.zero)
          report($sformatf("zero_norm %0b, expected %0b", out_zero_norm, e.zero));
      end
    end
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_MAX && !done_flag) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    sim_res_t fr;
    vec_row_t t;
    int       len, kind, sent;
    logic signed [ELEM_W-1:0] a, b;
    dot_acc = 0;
    sqa_acc = 0;
    sqb_acc = 0;

    // Directed: zero vectors, single pairs at the extremes, short mixed vectors
    add_row(row(0, 0, 1, 1, 0, 1));
    add_row(row(5, 0, 1, 1, 0, 1));
    add_row(row(0, -7, 1, 1, 0, 1));
    add_row(row(32767, 32767, 1, 1, 16384, 0));
    add_row(row(-32768, -32768, 1, 1, 16384, 0));
    add_row(row(-32768, 32767, 1, 1, -16384, 0));
    add_row(row(1, -1, 1, 1, -16384, 0));
    add_row(row(1, 0, 0));
    add_row(row(0, 1, 1, 1, 0, 0));
    add_row(row(3, 4, 0));
    add_row(row(-32768, 32767, 0));
    add_row(row(12345, -2, 1));
    add_row(row(21845, 10922, 0));
    add_row(row(-1, 32767, 0));
    add_row(row(0, 0, 0));
    add_row(row(-21846, 5461, 1));
    add_row(row(0, 9, 0));
    add_row(row(0, -9, 1, 1, 0, 1));
    add_row(row(-32768, 0, 0));
    add_row(row(0, 32767, 1, 1, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      t = dir_tab[i];
      fr.sim = t.sim;
      fr.zero = t.zero;
      send(t.a, t.b, t.last, t.fixed, fr);
    end

    // Long vector of extreme pairs builds large sums with no idling
    calm = 1'b1;
    for (int i = 0; i < SAT_LEN; i++)
      send(16'sh8000, (i % 3 == 0) ? 16'sh8000 : 16'sh7fff, i == SAT_LEN - 1);
    calm = 1'b0;

    // Random vectors: mostly short, related or independent operands
    sent = 0;
    while (sent < RND_CNT) begin
      len  = ($urandom_range(9) == 0) ? $urandom_range(64, 16) : $urandom_range(8, 1);
      kind = $urandom_range(5);
      calm = (sent > 700 && sent < 950);
      for (int i = 0; i < len; i++) begin
        a = rand_elem();
        case (kind)
          0: b = a;
          1: b = (a == 16'sh8000) ? 16'sh7fff : -a;
          2: b = (i % 2) ? 16'sh0000 : rand_elem();
          3: begin
            a = 16'sh0000;
            b = rand_elem();
          end
          default: b = rand_elem();
        endcase
        send(a, b, i == len - 1);
        sent++;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sim_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    done_flag = 1'b1;
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
